@@ hdl/rht_pkg.sv @@
// Shared types and constants for the reference-counted handle table.
package rht_pkg;

   localparam int MODE_W   = 3;
   localparam int HANDLE_W = 32;
   localparam int REFS_W   = 32;
   localparam int COUNT_W  = 6;

   localparam logic [MODE_W-1:0] MODE_CREATE     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ACTIVATE   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DEACTIVATE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ADD_REF    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RELEASE    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd5;

   // Write command from the sequencer to the slot store.
   typedef struct packed {
      logic                handle_we;
      logic                refs_we;
      logic [HANDLE_W-1:0] handle;
      logic [REFS_W-1:0]   refs;
   } rht_wr_type;

endpackage

@@ hdl/refcounted_handle_table.sv @@
// Top level of the reference-counted handle table.
//
// A table of SLOTS context slots, each live slot holding a handle and a reference
// count. For an operation, the lookup sequencer fetches and compares one slot per
// cycle from the slot memory; the scan stops at the first free or matching
// slot, then the update state writes that slot. A lookup that finds nothing
// answers with a failure. A count query, an unknown mode, or any operation while
// disabled answers without a scan. The block takes one word at a time and
// accepts the next after the result is taken. Writing enable from 0 to 1 frees
// every slot at once and restarts handles at 2. Activate and deactivate only
// report whether the handle is live, since the per-slot enabled flag has no
// visible effect.
module refcounted_handle_table #(
   parameter int SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // csr_data: enable
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,
   // req_tdata: context_id[31:0], zero padding [39:32]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // req_tuser: mode[2:0]
   input  logic [2:0]  req_tuser,
   // rsp_tdata: new_id[31:0], active_count[37:32], zero padding [39:38]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // rsp_tuser: ok[0]
   output logic [0:0]  rsp_tuser
);

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCAN_W = IDX_W + 1;
   localparam int LIVE_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOTS - 1);
   localparam logic [SCAN_W-1:0] SCAN_END  = SCAN_W'(SLOTS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_MOD  = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic                         enable_ff, enable_in;
   logic [SLOTS-1:0]             in_use_ff, in_use_in;
   logic [rht_pkg::HANDLE_W-1:0] next_handle_ff, next_handle_in;
   logic [LIVE_W-1:0]            live_ff, live_in;
   logic [rht_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [rht_pkg::HANDLE_W-1:0] id_ff, id_in;
   logic [SCAN_W-1:0]            scan_ff, scan_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]             chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0]             hit_idx_ff, hit_idx_in;
   logic [rht_pkg::REFS_W-1:0]   refs_hit_ff, refs_hit_in;
   logic                         rsp_ok_ff, rsp_ok_in;
   logic [rht_pkg::HANDLE_W-1:0] rsp_id_ff, rsp_id_in;
   logic [rht_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                         issue;
   logic                         hit;
   logic [rht_pkg::HANDLE_W-1:0] rd_handle;
   logic [rht_pkg::REFS_W-1:0]   rd_refs;
   logic [rht_pkg::HANDLE_W-1:0] handle_inc;
   logic [LIVE_W+rht_pkg::COUNT_W-1:0] live_wide;
   rht_pkg::rht_wr_type          wr;

   rht_store #(
      .SLOTS(SLOTS),
      .IDX_W(IDX_W)
   ) u_store (
      .clock     (clock),
      .rd_en     (issue),
      .rd_addr   (scan_ff[IDX_W-1:0]),
      .rd_handle (rd_handle),
      .rd_refs   (rd_refs),
      .wr_addr   (hit_idx_ff),
      .wr        (wr)
   );

   assign handle_inc = next_handle_ff + rht_pkg::HANDLE_W'(1);
   assign live_wide  = {{rht_pkg::COUNT_W{1'b0}}, live_in};

   // Issue stage reads one slot; check stage compares the slot read last cycle.
   always_comb begin
      if (!chk_vld_ff) begin
         hit = 1'b0;
      end else if (mode_ff == rht_pkg::MODE_CREATE) begin
         hit = !in_use_ff[chk_idx_ff];
      end else begin
         hit = in_use_ff[chk_idx_ff] && (rd_handle == id_ff);
      end
      issue = (state_ff == ST_SCAN) && (scan_ff < SCAN_END) && !hit;
   end

   always_comb begin
      state_in       = state_ff;
      enable_in      = enable_ff;
      in_use_in      = in_use_ff;
      next_handle_in = next_handle_ff;
      live_in        = live_ff;
      mode_in        = mode_ff;
      id_in          = id_ff;
      scan_in        = scan_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = chk_idx_ff;
      hit_idx_in     = hit_idx_ff;
      refs_hit_in    = refs_hit_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_count_in   = rsp_count_ff;
      wr             = '0;

      if (csr_valid) begin
         if (csr_data && !enable_ff) begin
            in_use_in      = '0;
            next_handle_in = rht_pkg::HANDLE_W'(1);
            live_in        = '0;
         end
         enable_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tuser;
               id_in   = req_tdata[rht_pkg::HANDLE_W-1:0];
               scan_in = '0;
               if (enable_ff && (req_tuser < rht_pkg::MODE_QUERY)) begin
                  state_in = ST_SCAN;
               end else begin
                  rsp_ok_in    = (req_tuser == rht_pkg::MODE_QUERY);
                  rsp_id_in    = '0;
                  rsp_count_in = live_wide[rht_pkg::COUNT_W-1:0];
                  state_in     = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + SCAN_W'(1);
            end
            if (hit) begin
               hit_idx_in  = chk_idx_ff;
               refs_hit_in = rd_refs;
               state_in    = ST_MOD;
            end else if (chk_vld_ff && (chk_idx_ff == LAST_IDX)) begin
               // No free or matching slot: fail.
               rsp_ok_in    = 1'b0;
               rsp_id_in    = '0;
               rsp_count_in = live_wide[rht_pkg::COUNT_W-1:0];
               state_in     = ST_RESP;
            end
         end
         ST_MOD: begin
            rsp_ok_in = 1'b1;
            rsp_id_in = '0;
            case (mode_ff)
               rht_pkg::MODE_CREATE: begin
                  next_handle_in        = handle_inc;
                  in_use_in[hit_idx_ff] = 1'b1;
                  live_in               = live_ff + LIVE_W'(1);
                  wr.handle_we          = 1'b1;
                  wr.handle             = handle_inc;
                  wr.refs_we            = 1'b1;
                  wr.refs               = rht_pkg::REFS_W'(1);
                  rsp_id_in             = handle_inc;
               end
               rht_pkg::MODE_ADD_REF: begin
                  // Hold the count at its maximum.
                  wr.refs_we = (refs_hit_ff != '1);
                  wr.refs    = refs_hit_ff + rht_pkg::REFS_W'(1);
               end
               rht_pkg::MODE_RELEASE: begin
                  wr.refs_we = 1'b1;
                  wr.refs    = refs_hit_ff - rht_pkg::REFS_W'(1);
                  if (refs_hit_ff == rht_pkg::REFS_W'(1)) begin
                     in_use_in[hit_idx_ff] = 1'b0;
                     live_in               = live_ff - LIVE_W'(1);
                  end
               end
               default: begin
                  // Activate and deactivate: success only.
               end
            endcase
            rsp_count_in = live_wide[rht_pkg::COUNT_W-1:0];
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         enable_ff      <= 1'b0;
         in_use_ff      <= '0;
         next_handle_ff <= rht_pkg::HANDLE_W'(1);
         live_ff        <= '0;
         chk_vld_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         enable_ff      <= enable_in;
         in_use_ff      <= in_use_in;
         next_handle_ff <= next_handle_in;
         live_ff        <= live_in;
         chk_vld_ff     <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      id_ff        <= id_in;
      scan_ff      <= scan_in;
      chk_idx_ff   <= chk_idx_in;
      hit_idx_ff   <= hit_idx_in;
      refs_hit_ff  <= refs_hit_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_ok_ff;

endmodule

@@ hdl/rht_store.sv @@
// Slot store: handle and reference count memories with registered reads.
module rht_store #(
   parameter int SLOTS = 32,
   parameter int IDX_W = 5
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [IDX_W-1:0]             rd_addr,
   output logic [rht_pkg::HANDLE_W-1:0] rd_handle,
   output logic [rht_pkg::REFS_W-1:0]   rd_refs,
   input  logic [IDX_W-1:0]             wr_addr,
   input  rht_pkg::rht_wr_type          wr
);

   logic [rht_pkg::HANDLE_W-1:0] handle_mem [SLOTS];
   logic [rht_pkg::REFS_W-1:0]   refs_mem   [SLOTS];
   logic [rht_pkg::HANDLE_W-1:0] rd_handle_ff;
   logic [rht_pkg::REFS_W-1:0]   rd_refs_ff;

   always_ff @(posedge clock) begin
      if (wr.handle_we) begin
         handle_mem[wr_addr] <= wr.handle;
      end
      if (wr.refs_we) begin
         refs_mem[wr_addr] <= wr.refs;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_handle_ff <= handle_mem[rd_addr];
         rd_refs_ff   <= refs_mem[rd_addr];
      end
   end

   assign rd_handle = rd_handle_ff;
   assign rd_refs   = rd_refs_ff;

endmodule

@@ test/refcounted_handle_table_tb.sv @@
// Self-checking testbench for the reference-counted handle table.
`timescale 1ns / 100ps

module refcounted_handle_table_tb;

   localparam int SLOTS       = 32;
   localparam int LATENCY     = SLOTS + 3;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;

   localparam logic [rht_pkg::MODE_W-1:0] MODE_UNKNOWN_LO = 3'd6;
   localparam logic [rht_pkg::MODE_W-1:0] MODE_UNKNOWN_HI = 3'd7;

   typedef struct packed {
      logic                         ok;
      logic [rht_pkg::HANDLE_W-1:0] new_id;
      logic [rht_pkg::COUNT_W-1:0]  live;
   } table_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // context_id[31:0], zero padding [39:32]
   logic [2:0]  req_tuser  = '0;   // mode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // new_id[31:0], active_count[37:32], padding [39:38]
   logic [0:0]  rsp_tuser;         // ok[0]

   refcounted_handle_table #(.SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // Table model
   logic                         slot_live  [SLOTS];
   logic [rht_pkg::HANDLE_W-1:0] slot_id    [SLOTS];
   logic                         slot_flag  [SLOTS];
   logic [rht_pkg::REFS_W-1:0]   slot_refs  [SLOTS];
   logic [rht_pkg::HANDLE_W-1:0] handle_ctr;
   logic [rht_pkg::COUNT_W-1:0]  live_total;
   logic                         table_on;

   table_result_type expected_results[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches    = 0;
   int stall_cycles  = 0;
   int words_sent    = 0;
   int results_seen  = 0;
   int creates_ok    = 0;
   int full_rejects  = 0;
   int peak_live     = 0;

   function automatic void clear_table_model();
      for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
      handle_ctr = 1;
      live_total = '0;
   endfunction

   function automatic void apply_enable_write(logic value);
      if (value && !table_on) clear_table_model();
      table_on = value;
   endfunction

   function automatic table_result_type predict_table_op(
      logic [rht_pkg::MODE_W-1:0] mode, logic [rht_pkg::HANDLE_W-1:0] id);
      table_result_type r;
      int               hit;
      r   = '0;
      hit = -1;
      if (mode == rht_pkg::MODE_QUERY) begin
         r.ok = 1'b1;
      end else if (mode <= rht_pkg::MODE_RELEASE && table_on) begin
         if (mode == rht_pkg::MODE_CREATE) begin
            for (int i = 0; i < SLOTS && hit < 0; i++) if (!slot_live[i]) hit = i;
            if (hit >= 0) begin
               handle_ctr      = handle_ctr + 1;
               slot_id[hit]    = handle_ctr;
               slot_flag[hit]  = 1'b1;
               slot_refs[hit]  = 1;
               slot_live[hit]  = 1'b1;
               live_total      = live_total + rht_pkg::COUNT_W'(1);
               r.new_id        = handle_ctr;
               r.ok            = 1'b1;
               creates_ok++;
               if (int'(live_total) > peak_live) peak_live = int'(live_total);
            end else begin
               full_rejects++;
            end
         end else begin
            // lowest matching live slot wins
            for (int i = 0; i < SLOTS && hit < 0; i++)
               if (slot_live[i] && slot_id[i] == id) hit = i;
            if (hit >= 0) begin
               r.ok = 1'b1;
               case (mode)
                  rht_pkg::MODE_ACTIVATE:   slot_flag[hit] = 1'b1;
                  rht_pkg::MODE_DEACTIVATE: slot_flag[hit] = 1'b0;
                  rht_pkg::MODE_ADD_REF: begin
                     if (slot_refs[hit] != '1) slot_refs[hit] = slot_refs[hit] + 1;
                  end
                  default: begin
                     slot_refs[hit] = slot_refs[hit] - 1;
                     if (slot_refs[hit] == 0) begin
                        slot_live[hit] = 1'b0;
                        live_total     = live_total - rht_pkg::COUNT_W'(1);
                     end
                  end
               endcase
            end
         end
      end
      r.live = live_total;
      return r;
   endfunction

   // Result checker, receiver stalls and stall counter
   always @(posedge clock) begin : check_results
      table_result_type want;
      logic             ok_bad, id_bad, live_bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("[%0t] unexpected result: ok=%0d new_id=%h count=%0d",
                        $realtime, rsp_tuser[0], rsp_tdata[31:0], rsp_tdata[37:32]);
            mismatches++;
         end else begin
            want     = expected_results.pop_front();
            ok_bad   = rsp_tuser[0] !== want.ok;
            id_bad   = rsp_tdata[31:0] !== want.new_id;
            live_bad = rsp_tdata[37:32] !== want.live;
            if (ok_bad || id_bad || live_bad) begin
               if (mismatches < MAX_REPORTS)
                  $display("[%0t] result mismatch: ok %0d/%0d new_id %h/%h count %0d/%0d %s",
                           $realtime, want.ok, rsp_tuser[0], want.new_id, rsp_tdata[31:0],
                           want.live, rsp_tdata[37:32], "(expected/actual)");
               mismatches++;
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("[%0t] no handshake for %0d cycles, %0d results outstanding",
               $realtime, STALL_LIMIT, expected_results.size());
      $display("end of test: mismatches");
      $finish;
   end

   task automatic send_word(logic [rht_pkg::MODE_W-1:0] mode,
                            logic [rht_pkg::HANDLE_W-1:0] id);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {8'h00, id};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(predict_table_op(mode, id));
      words_sent++;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Hold the sender until every expected word is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic write_enable(logic value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_enable_write(value);
      csr_valid <= 1'b0;
   endtask

   task automatic pick_random_item(bit grow, output logic [rht_pkg::MODE_W-1:0] mode,
                                   output logic [rht_pkg::HANDLE_W-1:0] id);
      logic [rht_pkg::HANDLE_W-1:0] live_ids[$];
      int                           r;
      for (int i = 0; i < SLOTS; i++) if (slot_live[i]) live_ids.push_back(slot_id[i]);
      r  = $urandom_range(99);
      id = $urandom;
      if (r < 8) begin
         mode = rht_pkg::MODE_W'($urandom_range(7));
      end else if (r < 12) begin
         // near-miss handles: recently issued or not yet issued
         mode = rht_pkg::MODE_W'($urandom_range(rht_pkg::MODE_RELEASE,
                                                rht_pkg::MODE_ACTIVATE));
         id   = handle_ctr + $urandom_range(3) - 2;
      end else begin
         r = $urandom_range(99);
         if (grow)
            mode = r < 50 ? rht_pkg::MODE_CREATE : r < 62 ? rht_pkg::MODE_RELEASE :
                   r < 72 ? rht_pkg::MODE_ADD_REF : r < 82 ? rht_pkg::MODE_ACTIVATE :
                   r < 92 ? rht_pkg::MODE_DEACTIVATE : rht_pkg::MODE_QUERY;
         else
            mode = r < 10 ? rht_pkg::MODE_CREATE : r < 70 ? rht_pkg::MODE_RELEASE :
                   r < 76 ? rht_pkg::MODE_ADD_REF : r < 84 ? rht_pkg::MODE_ACTIVATE :
                   r < 92 ? rht_pkg::MODE_DEACTIVATE : rht_pkg::MODE_QUERY;
         if (mode != rht_pkg::MODE_CREATE && mode != rht_pkg::MODE_QUERY &&
             live_ids.size() > 0)
            id = live_ids[$urandom_range(live_ids.size() - 1)];
      end
   endtask

   task automatic test_disabled();
      write_enable(1'b0);
      send_word(rht_pkg::MODE_QUERY, 32'h0);
      send_word(rht_pkg::MODE_CREATE, 32'hFFFF_FFFF);
      send_word(rht_pkg::MODE_RELEASE, 32'h2);
      send_word(MODE_UNKNOWN_HI, 32'h0);
      drain_results();
   endtask

   task automatic test_basic_ops();
      write_enable(1'b1);
      send_word(rht_pkg::MODE_CREATE, 32'h0);
      send_word(rht_pkg::MODE_CREATE, 32'h0);
      send_word(rht_pkg::MODE_CREATE, 32'hFFFF_FFFF);
      send_word(rht_pkg::MODE_ACTIVATE, 32'h3);
      send_word(rht_pkg::MODE_DEACTIVATE, 32'h3);
      send_word(rht_pkg::MODE_ADD_REF, 32'h2);
      send_word(rht_pkg::MODE_RELEASE, 32'h2);
      send_word(rht_pkg::MODE_RELEASE, 32'h2);
      send_word(rht_pkg::MODE_RELEASE, 32'h2);
      send_word(rht_pkg::MODE_ADD_REF, 32'hFFFF_FFFF);
      send_word(rht_pkg::MODE_ACTIVATE, 32'h0);
      send_word(MODE_UNKNOWN_LO, 32'h3);
      send_word(rht_pkg::MODE_QUERY, 32'hA5A5_5A5A);
      send_word(rht_pkg::MODE_CREATE, 32'h0);
      drain_results();
   endtask

   task automatic test_table_full();
      while (live_total < SLOTS) send_word(rht_pkg::MODE_CREATE, $urandom);
      send_word(rht_pkg::MODE_CREATE, 32'h0);
      // free a middle slot; the next create must land there
      while (slot_live[5]) send_word(rht_pkg::MODE_RELEASE, slot_id[5]);
      send_word(rht_pkg::MODE_CREATE, 32'h0);
      drain_results();
      write_enable(1'b0);
      send_word(rht_pkg::MODE_CREATE, 32'h0);
      send_word(rht_pkg::MODE_QUERY, 32'h0);
      drain_results();
      write_enable(1'b1);
      send_word(rht_pkg::MODE_QUERY, 32'h0);
      send_word(rht_pkg::MODE_CREATE, 32'h0);
      drain_results();
   endtask

   task automatic test_enable_rewrite();
      send_word(rht_pkg::MODE_CREATE, 32'h0);
      drain_results();
      write_enable(1'b1);
      send_word(rht_pkg::MODE_QUERY, 32'h0);
      send_word(rht_pkg::MODE_ADD_REF, 32'h3);
      drain_results();
   endtask

   task automatic test_random(int send_pct, int recv_pct, int items);
      logic [rht_pkg::MODE_W-1:0]   mode;
      logic [rht_pkg::HANDLE_W-1:0] id;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < items; n++) begin
         if (n > 0 && n % 160 == 0) begin
            drain_results();
            case ($urandom_range(2))
               0: write_enable(1'b1);
               1: begin
                  write_enable(1'b0);
                  repeat ($urandom_range(6, 3)) begin
                     pick_random_item(1'b1, mode, id);
                     send_word(mode, id);
                  end
                  drain_results();
                  write_enable(1'b1);
               end
               default: begin
                  write_enable(1'b0);
                  @(posedge clock);
                  write_enable(1'b1);
               end
            endcase
         end else if ($urandom_range(63) == 0) begin
            drain_results();
         end
         pick_random_item(((n / 80) % 2) == 0, mode, id);
         send_word(mode, id);
      end
      drain_results();
   endtask

   initial begin : run_tests
      table_on = 1'b0;
      clear_table_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 10;
      recv_idle_pct = 72;
      test_disabled();
      test_basic_ops();
      test_table_full();
      test_enable_rewrite();
      test_random(10, 72, 630);
      test_random(72, 10, 630);
      test_random(0, 0, 640);
      repeat (LATENCY + 5) @(posedge clock);
      $display("covered %0d requests and %0d results: %0d handles issued, %0d full-table rejects",
               words_sent, results_seen, creates_ok, full_rejects);
      $display("peak of %0d live slots, enable toggled between phases", peak_live);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
